@@ hw/rtl/elevator_order_controller_unit_defines.svh @@
// Assertion macros for the checker file eoc_checker.sv.
`ifndef ELEVATOR_ORDER_CONTROLLER_UNIT_DEFINES_SVH
`define ELEVATOR_ORDER_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define EOC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EOC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/eoc_pkg.sv @@
`default_nettype none

package eoc_pkg;

    localparam int LAMP_W = 4;
    localparam int IND_W = 2;
    localparam logic [15:0] HOLD_RESET = 16'd3000;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_UP    = 3'd1,
        MODE_DOWN  = 3'd2,
        MODE_WAIT  = 3'd3,
        MODE_EMERG = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        MOTOR_STOP = 2'd0,
        MOTOR_UP   = 2'd1,
        MOTOR_DOWN = 2'd2
    } motor_t;

    typedef struct packed {
        logic load;
        logic arrive;
        logic move;
        logic emit;
    } eoc_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/eoc_ctrl.sv @@
`default_nettype none

module eoc_ctrl
    import eoc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output eoc_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_MOVE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.load   = in_valid && in_ready_reg;
        cmd.arrive = (state_reg == ST_ARRIVE);
        cmd.move   = (state_reg == ST_MOVE);
        cmd.emit   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ARRIVE;
                end
            end
            ST_ARRIVE: state_next = ST_MOVE;
            ST_MOVE:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        in_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/eoc_datapath.sv @@
`default_nettype none

module eoc_datapath
    import eoc_pkg::*;
#(
    parameter int FLOORS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire eoc_cmd_t    cmd,
    input  wire logic        cfg_valid,
    input  wire logic [15:0] cfg_data,
    input  wire logic        at_floor,
    input  wire logic [1:0]  sensed_floor,
    input  wire logic [3:0]  hall_up_pressed,
    input  wire logic [3:0]  hall_down_pressed,
    input  wire logic [3:0]  cab_pressed,
    input  wire logic        stop_pressed,
    output logic [1:0]       motor_drive,
    output logic             door_open,
    output logic [3:0]       up_lamps,
    output logic [3:0]       down_lamps,
    output logic [3:0]       cab_lamps,
    output logic [1:0]       floor_indicator,
    output logic             stop_lamp,
    output logic [2:0]       mode
);

    localparam int LW = $clog2(FLOORS + 1) + 1;
    localparam logic signed [LW-1:0] LAST_ONE = LW'(1);
    localparam logic [FLOORS-1:0] BOT_MASK = FLOORS'(1);
    localparam logic [FLOORS-1:0] TOP_MASK = BOT_MASK << (FLOORS - 1);

    logic [15:0]              hold_cfg_reg, hold_cfg_next;
    logic [FLOORS-1:0]        up_reg, up_next;
    logic [FLOORS-1:0]        dn_reg, dn_next;
    logic [FLOORS-1:0]        cab_reg, cab_next;
    mode_t                    mode_reg, mode_next;
    logic                     dir_reg, dir_next;
    logic signed [LW-1:0]     last_reg, last_next;
    logic                     door_reg, door_next;
    logic [15:0]              hold_reg, hold_next;
    logic                     normal_reg, normal_next;
    motor_t                   motor_reg, motor_next;
    logic                     lamp_reg, lamp_next;
    logic [IND_W-1:0]         ind_reg, ind_next;
    logic                     floor_ok_reg, floor_ok_next;
    logic [1:0]               floor_reg, floor_next;

    motor_t                   motor_out_reg;
    logic                     door_out_reg;
    logic [LAMP_W-1:0]        up_out_reg, dn_out_reg, cab_out_reg;
    logic [IND_W-1:0]         ind_out_reg;
    logic                     lamp_out_reg;
    mode_t                    mode_out_reg;

    logic                     floor_ok;
    logic [FLOORS-1:0]        fhit_in, fhit_r, pending;
    logic [FLOORS-1:0]        up_add, dn_add, cab_add;
    logic [FLOORS-1:0]        above_f, below_f, above_l, below_l, at_l;
    logic [15:0]              hold_dec;
    logic                     o_up, o_dn, o_cab, stop_here, at_top, at_bottom;

    always_comb
    begin
        for (int i = 0; i < FLOORS; i++)
        begin
            above_f[i] = (i > int'(floor_reg));
            below_f[i] = (i < int'(floor_reg));
            above_l[i] = (i > int'(last_reg));
            below_l[i] = (i < int'(last_reg));
            at_l[i]    = (i == int'(last_reg));
        end
    end

    assign floor_ok  = at_floor && (int'(sensed_floor) < FLOORS);
    assign fhit_in   = floor_ok ? (BOT_MASK << sensed_floor) : '0;
    assign fhit_r    = BOT_MASK << floor_reg;
    assign pending   = up_reg | dn_reg | cab_reg;
    assign up_add    = FLOORS'(hall_up_pressed) & ~TOP_MASK;
    assign dn_add    = FLOORS'(hall_down_pressed) & ~BOT_MASK;
    assign cab_add   = FLOORS'(cab_pressed);
    assign hold_dec  = (hold_reg != 16'd0) ? (hold_reg - 16'd1) : hold_reg;
    assign o_up      = |(up_reg & fhit_r);
    assign o_dn      = |(dn_reg & fhit_r);
    assign o_cab     = |(cab_reg & fhit_r);
    assign at_top    = floor_ok_reg && (int'(floor_reg) == FLOORS - 1);
    assign at_bottom = floor_ok_reg && (floor_reg == 2'd0);

    always_comb
    begin
        stop_here = o_cab
            || (dir_reg && o_up) || (!dir_reg && o_dn)
            || (dir_reg && o_dn && !(|(pending & above_f)))
            || (!dir_reg && o_up && !(|(pending & below_f)));
    end

    always_comb
    begin
        hold_cfg_next = cfg_valid ? cfg_data : hold_cfg_reg;
        up_next       = up_reg;
        dn_next       = dn_reg;
        cab_next      = cab_reg;
        mode_next     = mode_reg;
        dir_next      = dir_reg;
        last_next     = last_reg;
        door_next     = door_reg;
        hold_next     = hold_reg;
        normal_next   = normal_reg;
        motor_next    = motor_reg;
        lamp_next     = lamp_reg;
        ind_next      = ind_reg;
        floor_ok_next = floor_ok_reg;
        floor_next    = floor_reg;

        // Mode entry, stop switch and order latching
        if (cmd.load)
        begin
            floor_ok_next = floor_ok;
            floor_next    = sensed_floor;
            hold_next     = hold_dec;
            motor_next    = MOTOR_STOP;
            lamp_next     = 1'b0;
            normal_next   = 1'b0;
            if (mode_reg == MODE_INIT)
            begin
                dir_next = 1'b1;
                if (floor_ok)
                begin
                    last_next = LW'(sensed_floor);
                    door_next = 1'b1;
                    hold_next = hold_cfg_reg;
                    mode_next = MODE_WAIT;
                end
                else
                begin
                    motor_next = MOTOR_UP;
                end
            end
            else if (stop_pressed)
            begin
                mode_next = MODE_EMERG;
                up_next   = '0;
                dn_next   = '0;
                cab_next  = '0;
                lamp_next = 1'b1;
                if (floor_ok)
                begin
                    last_next = LW'(sensed_floor);
                    door_next = 1'b1;
                    hold_next = hold_cfg_reg;
                end
            end
            else if (mode_reg == MODE_EMERG)
            begin
                if (floor_ok)
                begin
                    last_next = LW'(sensed_floor);
                    if (hold_dec == 16'd0)
                    begin
                        door_next = 1'b0;
                    end
                end
                mode_next = MODE_WAIT;
            end
            else
            begin
                normal_next = 1'b1;
                up_next  = (up_reg | up_add) & ~(door_reg ? fhit_in : '0);
                dn_next  = (dn_reg | dn_add) & ~(door_reg ? fhit_in : '0);
                cab_next = (cab_reg | cab_add) & ~(door_reg ? fhit_in : '0);
            end
        end

        // Stop decision at the sensed floor
        if (cmd.arrive && normal_reg && floor_ok_reg)
        begin
            last_next = LW'(floor_reg);
            if (stop_here)
            begin
                if (mode_reg != MODE_WAIT)
                begin
                    door_next = 1'b1;
                    hold_next = hold_cfg_reg;
                end
                mode_next = MODE_WAIT;
            end
        end

        // Travel and dispatch
        if (cmd.move)
        begin
            if (last_reg < 0)
            begin
                ind_next = '0;
            end
            else if (int'(last_reg) > FLOORS - 1)
            begin
                ind_next = IND_W'(FLOORS - 1);
            end
            else
            begin
                ind_next = IND_W'(last_reg);
            end

            if (normal_reg)
            begin
                case (mode_reg)
                    MODE_UP:
                    begin
                        door_next  = 1'b0;
                        dir_next   = 1'b1;
                        motor_next = MOTOR_UP;
                        if (at_top)
                        begin
                            door_next  = 1'b1;
                            hold_next  = hold_cfg_reg;
                            mode_next  = MODE_WAIT;
                            motor_next = MOTOR_STOP;
                        end
                    end
                    MODE_DOWN:
                    begin
                        door_next  = 1'b0;
                        dir_next   = 1'b0;
                        motor_next = MOTOR_DOWN;
                        if (at_bottom)
                        begin
                            door_next  = 1'b1;
                            hold_next  = hold_cfg_reg;
                            mode_next  = MODE_WAIT;
                            motor_next = MOTOR_STOP;
                        end
                    end
                    MODE_WAIT:
                    begin
                        if (hold_reg == 16'd0)
                        begin
                            door_next = 1'b0;
                            if (dir_reg)
                            begin
                                if (|(pending & above_l))
                                begin
                                    mode_next = MODE_UP;
                                end
                                else if (|pending)
                                begin
                                    mode_next = MODE_DOWN;
                                    if (|(pending & at_l))
                                    begin
                                        last_next = last_reg + LAST_ONE;
                                    end
                                end
                            end
                            else
                            begin
                                if (|(pending & below_l))
                                begin
                                    mode_next = MODE_DOWN;
                                end
                                else if (|pending)
                                begin
                                    mode_next = MODE_UP;
                                    if (|(pending & at_l))
                                    begin
                                        last_next = last_reg - LAST_ONE;
                                    end
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cfg_reg <= HOLD_RESET;
            up_reg       <= '0;
            dn_reg       <= '0;
            cab_reg      <= '0;
            mode_reg     <= MODE_INIT;
            dir_reg      <= 1'b1;
            last_reg     <= '0;
            door_reg     <= 1'b0;
            hold_reg     <= '0;
            normal_reg   <= 1'b0;
            motor_reg    <= MOTOR_STOP;
            lamp_reg     <= 1'b0;
            ind_reg      <= '0;
            floor_ok_reg <= 1'b0;
            floor_reg    <= '0;
        end
        else
        begin
            hold_cfg_reg <= hold_cfg_next;
            up_reg       <= up_next;
            dn_reg       <= dn_next;
            cab_reg      <= cab_next;
            mode_reg     <= mode_next;
            dir_reg      <= dir_next;
            last_reg     <= last_next;
            door_reg     <= door_next;
            hold_reg     <= hold_next;
            normal_reg   <= normal_next;
            motor_reg    <= motor_next;
            lamp_reg     <= lamp_next;
            ind_reg      <= ind_next;
            floor_ok_reg <= floor_ok_next;
            floor_reg    <= floor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            motor_out_reg <= motor_reg;
            door_out_reg  <= door_reg;
            up_out_reg    <= LAMP_W'(up_reg);
            dn_out_reg    <= LAMP_W'(dn_reg);
            cab_out_reg   <= LAMP_W'(cab_reg);
            ind_out_reg   <= ind_reg;
            lamp_out_reg  <= lamp_reg;
            mode_out_reg  <= mode_reg;
        end
    end

    assign motor_drive     = motor_out_reg;
    assign door_open       = door_out_reg;
    assign up_lamps        = up_out_reg;
    assign down_lamps      = dn_out_reg;
    assign cab_lamps       = cab_out_reg;
    assign floor_indicator = ind_out_reg;
    assign stop_lamp       = lamp_out_reg;
    assign mode            = mode_out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/elevator_order_controller_unit.sv @@
// Channel   Handshake             Payload
// input     in_valid / in_ready   at_floor, sensed_floor, hall/cab buttons, stop_pressed
// output    out_valid / out_ready motor_drive, door_open, lamps, floor_indicator,
//                                 stop_lamp, mode
// config    cfg_valid / cfg_ready cfg_data (door hold in ticks)
//
// Each item passes through accept with order latching, stop decision, travel
// and dispatch, then the load of the output register.
// The output register parts the two sides; a new item is taken while a result waits.
// A stalled output holds the sequencer in its last step until the result is taken.
// Reset clears the orders, starts in init mode with a hold of 3000 ticks;
// cfg_ready is always high.
`default_nettype none

module elevator_order_controller_unit
    import eoc_pkg::*;
#(
    parameter int FLOORS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        at_floor,
    input  wire logic [1:0]  sensed_floor,
    input  wire logic [3:0]  hall_up_pressed,
    input  wire logic [3:0]  hall_down_pressed,
    input  wire logic [3:0]  cab_pressed,
    input  wire logic        stop_pressed,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       motor_drive,
    output logic             door_open,
    output logic [3:0]       up_lamps,
    output logic [3:0]       down_lamps,
    output logic [3:0]       cab_lamps,
    output logic [1:0]       floor_indicator,
    output logic             stop_lamp,
    output logic [2:0]       mode
);

    eoc_cmd_t cmd;

    assign cfg_ready = 1'b1;

    eoc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    eoc_datapath #(
        .FLOORS (FLOORS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_valid         (cfg_valid),
        .cfg_data          (cfg_data),
        .at_floor          (at_floor),
        .sensed_floor      (sensed_floor),
        .hall_up_pressed   (hall_up_pressed),
        .hall_down_pressed (hall_down_pressed),
        .cab_pressed       (cab_pressed),
        .stop_pressed      (stop_pressed),
        .motor_drive       (motor_drive),
        .door_open         (door_open),
        .up_lamps          (up_lamps),
        .down_lamps        (down_lamps),
        .cab_lamps         (cab_lamps),
        .floor_indicator   (floor_indicator),
        .stop_lamp         (stop_lamp),
        .mode              (mode)
    );

endmodule

`default_nettype wire

@@ hw/rtl/eoc_checker.sv @@
`default_nettype none

`include "elevator_order_controller_unit_defines.svh"

module eoc_checker
    import eoc_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] motor_drive,
    input wire logic       door_open,
    input wire logic       stop_lamp,
    input wire logic [2:0] mode
);

    `EOC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(mode) && $stable(door_open), "stalled item changed")
    `EOC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "ready right after accept")
    `EOC_ASSERT_IMP(a_emerg, clk, rst_n, out_valid && stop_lamp, motor_drive == MOTOR_STOP && mode == MODE_EMERG, "stop lamp without emergency stop")
    `EOC_ASSERT_IMP(a_init, clk, rst_n, out_valid && mode == MODE_INIT, motor_drive == MOTOR_UP && !door_open, "init must drive up with door closed")
    `EOC_ASSERT_IMP(a_door_motor, clk, rst_n, out_valid && motor_drive != MOTOR_STOP, !door_open, "motor driving with door open")

endmodule

bind elevator_order_controller_unit eoc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .motor_drive (motor_drive),
    .door_open   (door_open),
    .stop_lamp   (stop_lamp),
    .mode        (mode)
);

`default_nettype wire

@@ sim/elevator_order_controller_unit_tb.sv @@
`timescale 1ns / 100ps

module elevator_order_controller_unit_tb;
    import eoc_pkg::*;

    localparam int NUM_FLOORS = 4;
    localparam logic [2:0] ORD_UP = 3'b001;
    localparam logic [2:0] ORD_DOWN = 3'b010;
    localparam logic [2:0] ORD_CAB = 3'b100;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES = 8;
    localparam int DIR_ROWS = 25;
    localparam int LONG_STALL_AFTER = 300;
    localparam int LONG_STALL_CYCLES = 400;

    typedef struct packed {
        logic       at_floor;
        logic [1:0] sensed_floor;
        logic [3:0] hall_up;
        logic [3:0] hall_down;
        logic [3:0] cab;
        logic       stop;
    } tick_t;

    typedef struct packed {
        motor_t     motor;
        logic       door;
        logic [3:0] up_lamps;
        logic [3:0] down_lamps;
        logic [3:0] cab_lamps;
        logic [1:0] indicator;
        logic       stop_lamp;
        mode_t      car_mode;
    } car_status_t;

    typedef struct {
        logic        set_hold;
        logic [15:0] hold;
        tick_t       tick;
        logic        typed;
        car_status_t want;
    } dir_row_t;

    localparam car_status_t NO_CHECK = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        at_floor = 1'b0;
    logic [1:0]  sensed_floor = 2'd0;
    logic [3:0]  hall_up_pressed = 4'h0;
    logic [3:0]  hall_down_pressed = 4'h0;
    logic [3:0]  cab_pressed = 4'h0;
    logic        stop_pressed = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  motor_drive;
    logic        door_open;
    logic [3:0]  up_lamps;
    logic [3:0]  down_lamps;
    logic [3:0]  cab_lamps;
    logic [1:0]  floor_indicator;
    logic        stop_lamp;
    logic [2:0]  mode;

    logic [2:0]  orders [NUM_FLOORS];
    mode_t       car_mode;
    logic        heading_up;
    int          last_floor;
    logic        door_flag;
    logic [15:0] hold_left;
    logic [15:0] hold_ticks;

    car_status_t pending_status [$];
    car_status_t seen;
    motor_t      last_motor = MOTOR_STOP;
    int          mismatches = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{1'b0, 16'd0, '{1'b0, 2'd3, 4'hF, 4'hF, 4'hF, 1'b1}, 1'b1,
          '{MOTOR_UP, 1'b0, 4'h0, 4'h0, 4'h0, 2'd0, 1'b0, MODE_INIT}},
        '{1'b0, 16'd0, '{1'b1, 2'd2, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b1,
          '{MOTOR_STOP, 1'b1, 4'h0, 4'h0, 4'h0, 2'd2, 1'b0, MODE_WAIT}},
        '{1'b0, 16'd0, '{1'b1, 2'd2, 4'hF, 4'hF, 4'hF, 1'b0}, 1'b1,
          '{MOTOR_STOP, 1'b1, 4'h3, 4'hA, 4'hB, 2'd2, 1'b0, MODE_WAIT}},
        '{1'b0, 16'd0, '{1'b1, 2'd2, 4'h0, 4'h0, 4'h0, 1'b1}, 1'b1,
          '{MOTOR_STOP, 1'b1, 4'h0, 4'h0, 4'h0, 2'd2, 1'b1, MODE_EMERG}},
        '{1'b0, 16'd0, '{1'b0, 2'd1, 4'hF, 4'hF, 4'hF, 1'b1}, 1'b1,
          '{MOTOR_STOP, 1'b1, 4'h0, 4'h0, 4'h0, 2'd2, 1'b1, MODE_EMERG}},
        '{1'b0, 16'd0, '{1'b1, 2'd2, 4'hF, 4'hF, 4'hF, 1'b0}, 1'b1,
          '{MOTOR_STOP, 1'b1, 4'h0, 4'h0, 4'h0, 2'd2, 1'b0, MODE_WAIT}},
        '{1'b1, 16'd1, '{1'b1, 2'd2, 4'h0, 4'h0, 4'h0, 1'b1}, 1'b1,
          '{MOTOR_STOP, 1'b1, 4'h0, 4'h0, 4'h0, 2'd2, 1'b1, MODE_EMERG}},
        '{1'b0, 16'd0, '{1'b1, 2'd2, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b1,
          '{MOTOR_STOP, 1'b0, 4'h0, 4'h0, 4'h0, 2'd2, 1'b0, MODE_WAIT}},
        '{1'b0, 16'd0, '{1'b1, 2'd2, 4'h0, 4'h0, 4'h4, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b0, 2'd1, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b1, 2'd2, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b1, 2'd2, 4'h8, 4'h1, 4'h1, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b0, 2'd3, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b1, 2'd1, 4'h2, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b0, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b1, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b1, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b0, 2'd2, 4'h0, 4'h0, 4'h8, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b1, 2'd1, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b1, 16'd0, '{1'b1, 2'd1, 4'h0, 4'h0, 4'h0, 1'b1}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b1, 2'd1, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b1, 2'd1, 4'h0, 4'h4, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b0, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b1, 2'd2, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, NO_CHECK},
        '{1'b0, 16'd0, '{1'b1, 2'd3, 4'h5, 4'h6, 4'h8, 1'b0}, 1'b0, NO_CHECK}
    };

    elevator_order_controller_unit DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .at_floor          (at_floor),
        .sensed_floor      (sensed_floor),
        .hall_up_pressed   (hall_up_pressed),
        .hall_down_pressed (hall_down_pressed),
        .cab_pressed       (cab_pressed),
        .stop_pressed      (stop_pressed),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .motor_drive       (motor_drive),
        .door_open         (door_open),
        .up_lamps          (up_lamps),
        .down_lamps        (down_lamps),
        .cab_lamps         (cab_lamps),
        .floor_indicator   (floor_indicator),
        .stop_lamp         (stop_lamp),
        .mode              (mode)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic orders_above();
        int i;
        i = (last_floor + 1 < 0) ? 0 : last_floor + 1;
        while (i < NUM_FLOORS)
        begin
            if (orders[i] != 3'b000)
                return 1'b1;
            i++;
        end
        return 1'b0;
    endfunction

    function automatic logic orders_below();
        int i;
        i = (last_floor - 1 > NUM_FLOORS - 1) ? NUM_FLOORS - 1 : last_floor - 1;
        while (i >= 0)
        begin
            if (orders[i] != 3'b000)
                return 1'b1;
            i--;
        end
        return 1'b0;
    endfunction

    function automatic void park_car();
        if (car_mode != MODE_WAIT && car_mode != MODE_EMERG)
        begin
            door_flag = 1'b1;
            hold_left = hold_ticks;
        end
        car_mode = MODE_WAIT;
    endfunction

    function automatic void dispatch_car();
        int i;
        for (i = 0; i < NUM_FLOORS; i++)
        begin
            if (orders[i] == 3'b000)
                continue;
            if (i > last_floor)
                car_mode = MODE_UP;
            else if (i < last_floor)
                car_mode = MODE_DOWN;
            else if (heading_up)
            begin
                last_floor++;
                car_mode = MODE_DOWN;
            end
            else
            begin
                last_floor--;
                car_mode = MODE_UP;
            end
        end
    endfunction

    function automatic car_status_t advance_car(tick_t t);
        int          i;
        int          fl;
        int          ind;
        logic        halt;
        logic [2:0]  here;
        car_status_t res;
        res = '0;
        res.motor = MOTOR_STOP;
        fl = (t.at_floor && int'(t.sensed_floor) < NUM_FLOORS) ? int'(t.sensed_floor) : -1;
        if (hold_left != 16'd0)
            hold_left--;
        if (car_mode == MODE_INIT)
        begin
            heading_up = 1'b1;
            if (fl >= 0)
            begin
                last_floor = fl;
                park_car();
            end
            else
                res.motor = MOTOR_UP;
            ind = last_floor;
        end
        else if (t.stop)
        begin
            car_mode = MODE_EMERG;
            for (i = 0; i < NUM_FLOORS; i++)
                orders[i] = 3'b000;
            if (fl >= 0)
            begin
                last_floor = fl;
                door_flag = 1'b1;
                hold_left = hold_ticks;
            end
            res.stop_lamp = 1'b1;
            ind = last_floor;
        end
        else if (car_mode == MODE_EMERG)
        begin
            if (fl >= 0)
            begin
                last_floor = fl;
                if (hold_left == 16'd0)
                    door_flag = 1'b0;
            end
            car_mode = MODE_WAIT;
            ind = last_floor;
        end
        else
        begin
            for (i = 0; i < NUM_FLOORS; i++)
            begin
                if (i != 0 && t.hall_down[i])
                    orders[i] |= ORD_DOWN;
                if (i != NUM_FLOORS - 1 && t.hall_up[i])
                    orders[i] |= ORD_UP;
                if (t.cab[i])
                    orders[i] |= ORD_CAB;
            end
            if (fl >= 0 && door_flag)
                orders[fl] = 3'b000;
            if (fl >= 0)
            begin
                here = orders[fl];
                halt = (here & ORD_CAB) != 3'b000;
                last_floor = fl;
                if (heading_up && (here & ORD_UP) != 3'b000)
                    halt = 1'b1;
                if (!heading_up && (here & ORD_DOWN) != 3'b000)
                    halt = 1'b1;
                if (heading_up && (here & ORD_DOWN) != 3'b000 && !orders_above())
                    halt = 1'b1;
                if (!heading_up && (here & ORD_UP) != 3'b000 && !orders_below())
                    halt = 1'b1;
                if (halt)
                    park_car();
            end
            ind = last_floor;
            if (car_mode == MODE_UP)
            begin
                door_flag = 1'b0;
                heading_up = 1'b1;
                res.motor = MOTOR_UP;
                if (fl == NUM_FLOORS - 1)
                begin
                    park_car();
                    res.motor = MOTOR_STOP;
                end
            end
            else if (car_mode == MODE_DOWN)
            begin
                door_flag = 1'b0;
                heading_up = 1'b0;
                res.motor = MOTOR_DOWN;
                if (fl == 0)
                begin
                    park_car();
                    res.motor = MOTOR_STOP;
                end
            end
            else if (car_mode == MODE_WAIT && hold_left == 16'd0)
            begin
                door_flag = 1'b0;
                if (heading_up)
                begin
                    if (orders_above())
                        car_mode = MODE_UP;
                    else
                        dispatch_car();
                end
                else
                begin
                    if (orders_below())
                        car_mode = MODE_DOWN;
                    else
                        dispatch_car();
                end
            end
        end
        if (ind < 0)
            ind = 0;
        if (ind > NUM_FLOORS - 1)
            ind = NUM_FLOORS - 1;
        for (i = 0; i < NUM_FLOORS; i++)
        begin
            res.up_lamps[i] = orders[i][0];
            res.down_lamps[i] = orders[i][1];
            res.cab_lamps[i] = orders[i][2];
        end
        res.indicator = 2'(ind);
        res.door = door_flag;
        res.car_mode = car_mode;
        return res;
    endfunction

    function automatic void check_status(car_status_t want, car_status_t got);
        if (got.motor !== want.motor)
        begin
            $error("motor_drive: expected %0d, got %0d", want.motor, got.motor);
            mismatches++;
        end
        if (got.door !== want.door)
        begin
            $error("door_open: expected %0d, got %0d", want.door, got.door);
            mismatches++;
        end
        if (got.up_lamps !== want.up_lamps)
        begin
            $error("up_lamps: expected %h, got %h", want.up_lamps, got.up_lamps);
            mismatches++;
        end
        if (got.down_lamps !== want.down_lamps)
        begin
            $error("down_lamps: expected %h, got %h", want.down_lamps, got.down_lamps);
            mismatches++;
        end
        if (got.cab_lamps !== want.cab_lamps)
        begin
            $error("cab_lamps: expected %h, got %h", want.cab_lamps, got.cab_lamps);
            mismatches++;
        end
        if (got.indicator !== want.indicator)
        begin
            $error("floor_indicator: expected %0d, got %0d", want.indicator, got.indicator);
            mismatches++;
        end
        if (got.stop_lamp !== want.stop_lamp)
        begin
            $error("stop_lamp: expected %0d, got %0d", want.stop_lamp, got.stop_lamp);
            mismatches++;
        end
        if (got.car_mode !== want.car_mode)
        begin
            $error("mode: expected %0d, got %0d", want.car_mode, got.car_mode);
            mismatches++;
        end
    endfunction

    function automatic logic [3:0] press_mask();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 4'h0;
        else if (r < 92)
            return 4'h1 << $urandom_range(0, 3);
        else
            return 4'($urandom_range(0, 15));
    endfunction

    task automatic offer_tick(input tick_t t, input logic typed, input car_status_t want);
        logic        taken;
        car_status_t pred;
        in_valid <= 1'b1;
        at_floor <= t.at_floor;
        sensed_floor <= t.sensed_floor;
        hall_up_pressed <= t.hall_up;
        hall_down_pressed <= t.hall_down;
        cab_pressed <= t.cab;
        stop_pressed <= t.stop;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            if (taken)
            begin
                pred = advance_car(t);
                pending_status.push_back(typed ? want : pred);
                last_motor = pred.motor;
            end
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic sender_gap(input logic allow);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (!allow || r < 55)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(4, 40);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_hold(input logic [15:0] value);
        logic taken;
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        hold_ticks = value;
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.motor = motor_t'(motor_drive);
            seen.door = door_open;
            seen.up_lamps = up_lamps;
            seen.down_lamps = down_lamps;
            seen.cab_lamps = cab_lamps;
            seen.indicator = floor_indicator;
            seen.stop_lamp = stop_lamp;
            seen.car_mode = mode_t'(mode);
            if (pending_status.size() == 0)
            begin
                $error("result arrived with no tick outstanding");
                mismatches++;
            end
            else
                check_status(pending_status.pop_front(), seen);
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int   stall_left;
        int   steady_left;
        int   r;
        logic long_done;
        stall_left = 0;
        steady_left = 0;
        long_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_done && results_seen >= LONG_STALL_AFTER)
            begin
                // hold off long enough to back the block up into its input
                long_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
            end
            else if (steady_left > 0)
            begin
                out_ready <= 1'b1;
                steady_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    out_ready <= 1'b1;
                else if (r < 70)
                begin
                    out_ready <= 1'b1;
                    steady_left = $urandom_range(20, 80);
                end
                else
                begin
                    out_ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
                end
            end
        end
    end

    initial
    begin
        int          i;
        int          k;
        int          phase;
        int          n_items;
        int          car_pos;
        int          stop_run;
        logic [15:0] hold_val;
        tick_t       t;
        for (i = 0; i < NUM_FLOORS; i++)
            orders[i] = 3'b000;
        car_mode = MODE_INIT;
        heading_up = 1'b1;
        last_floor = 0;
        door_flag = 1'b0;
        hold_left = 16'd0;
        hold_ticks = HOLD_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_table[k].set_hold)
                write_hold(dir_table[k].hold);
            offer_tick(dir_table[k].tick, dir_table[k].typed, dir_table[k].want);
            sender_gap(1'b1);
        end

        // car position in half floors: even is at a floor, odd is between
        car_pos = (last_floor < 0) ? 0 : ((last_floor > NUM_FLOORS - 1) ? 6 : 2 * last_floor);
        stop_run = 0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                hold_val = 16'd1;
            else if (phase == 1)
                hold_val = 16'hFFFF;
            else if (phase == 2)
                hold_val = 16'd0;
            else
                hold_val = 16'($urandom_range(1, 12));
            write_hold(hold_val);
            n_items = (phase == 1) ? 40 : 120;
            for (k = 0; k < n_items; k++)
            begin
                t.at_floor = (car_pos % 2 == 0);
                t.sensed_floor = t.at_floor ? 2'(car_pos / 2) : 2'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 5)
                begin
                    t.at_floor = 1'($urandom_range(0, 1));
                    t.sensed_floor = 2'($urandom_range(0, 3));
                end
                t.hall_up = press_mask();
                t.hall_down = press_mask();
                t.cab = press_mask();
                if (stop_run > 0)
                begin
                    t.stop = 1'b1;
                    stop_run--;
                end
                else if ($urandom_range(0, 49) == 0)
                begin
                    t.stop = 1'b1;
                    stop_run = $urandom_range(0, 3);
                end
                else
                    t.stop = 1'b0;
                offer_tick(t, 1'b0, NO_CHECK);
                // advance the car the way the motor drives it
                if (last_motor == MOTOR_UP && car_pos < 2 * (NUM_FLOORS - 1)
                    && $urandom_range(0, 1) == 1)
                    car_pos++;
                else if (last_motor == MOTOR_DOWN && car_pos > 0 && $urandom_range(0, 1) == 1)
                    car_pos--;
                sender_gap(k >= 30);
            end
        end

        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ elevator_order_controller_unit.f @@
+incdir+hw/rtl
hw/rtl/eoc_pkg.sv
hw/rtl/eoc_ctrl.sv
hw/rtl/eoc_datapath.sv
hw/rtl/elevator_order_controller_unit.sv
hw/rtl/eoc_checker.sv
sim/elevator_order_controller_unit_tb.sv
